@@ hw/rtl/a2ab_pkg.sv @@
// Shared types and constants for the avcC to Annex B converter.
// No dependencies; imported by every module of the block.
package a2ab_pkg;

    localparam logic [7:0] SPS_COUNT_MASK = 8'h1F;
    localparam logic [2:0] HEADER_LAST    = 3'd5;   // header byte that holds the SPS count
    localparam logic [7:0] SC_ZERO        = 8'h00;
    localparam logic [7:0] SC_ONE         = 8'h01;
    localparam logic [1:0] SC_LAST_BEAT   = 2'd3;

    localparam logic KIND_SPS = 1'b0;
    localparam logic KIND_PPS = 1'b1;

    typedef enum logic [2:0] {
        PH_HEADER    = 3'd0,
        PH_LEN_HI    = 3'd1,
        PH_LEN_LO    = 3'd2,
        PH_PAYLOAD   = 3'd3,
        PH_PPS_COUNT = 3'd4,
        PH_DONE      = 3'd5
    } t_phase;

    // One queued command: either a full start code or one payload byte
    typedef struct packed {
        logic       is_sc;
        logic [7:0] data;
        logic       kind;
        logic       unit_end;
    } t_cmd;

endpackage

@@ hw/rtl/a2ab_front.sv @@
// Record parser: accepts avcC bytes and turns them into start-code / payload commands.
// Depends on a2ab_pkg.
module a2ab_front
    import a2ab_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_in_byte,
    input  logic       i_record_start,
    output logic       o_push,
    output t_cmd       o_cmd
);

    t_phase      r_phase, n_phase;
    logic [2:0]  r_header_index, n_header_index;
    logic [7:0]  r_sets_left, n_sets_left;
    logic [7:0]  r_length_high, n_length_high;
    logic [15:0] r_payload_left, n_payload_left;
    logic        r_kind, n_kind;

    t_phase      eff_phase;
    logic [2:0]  eff_index;
    logic [7:0]  sets_dec;
    logic [15:0] len_full;
    logic [15:0] pay_dec;
    t_phase      finish_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HEADER;
            r_header_index <= '0;
            r_sets_left    <= '0;
            r_length_high  <= '0;
            r_payload_left <= '0;
            r_kind         <= KIND_SPS;
        end else begin
            r_phase        <= n_phase;
            r_header_index <= n_header_index;
            r_sets_left    <= n_sets_left;
            r_length_high  <= n_length_high;
            r_payload_left <= n_payload_left;
            r_kind         <= n_kind;
        end
    end

    always_comb begin
        // record_start restarts the parser on this very byte
        eff_phase = i_record_start ? PH_HEADER : r_phase;
        eff_index = i_record_start ? 3'd0 : r_header_index;
        sets_dec  = r_sets_left - 8'd1;
        len_full  = {r_length_high, i_in_byte};
        pay_dec   = r_payload_left - 16'd1;

        if (sets_dec != 8'd0) begin
            finish_phase = PH_LEN_HI;
        end else if (r_kind == KIND_SPS) begin
            finish_phase = PH_PPS_COUNT;
        end else begin
            finish_phase = PH_DONE;
        end

        n_phase        = r_phase;
        n_header_index = r_header_index;
        n_sets_left    = r_sets_left;
        n_length_high  = r_length_high;
        n_payload_left = r_payload_left;
        n_kind         = r_kind;
        o_push         = 1'b0;
        o_cmd          = '0;
        o_cmd.kind     = r_kind;

        if (i_accept) begin
            n_phase        = eff_phase;
            n_header_index = eff_index;
            case (eff_phase)
                PH_HEADER: begin
                    if (eff_index == HEADER_LAST) begin
                        n_sets_left    = i_in_byte & SPS_COUNT_MASK;
                        n_kind         = KIND_SPS;
                        n_header_index = '0;
                        n_phase        = ((i_in_byte & SPS_COUNT_MASK) != 8'd0)
                                         ? PH_LEN_HI : PH_PPS_COUNT;
                    end else begin
                        n_header_index = eff_index + 3'd1;
                    end
                end
                PH_LEN_HI: begin
                    n_length_high = i_in_byte;
                    n_phase       = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_payload_left = len_full;
                    o_push         = 1'b1;
                    o_cmd.is_sc    = 1'b1;
                    o_cmd.unit_end = (len_full == 16'd0);
                    if (len_full == 16'd0) begin
                        n_sets_left = sets_dec;
                        n_phase     = finish_phase;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    n_payload_left = pay_dec;
                    o_push         = 1'b1;
                    o_cmd.data     = i_in_byte;
                    o_cmd.unit_end = (pay_dec == 16'd0);
                    if (pay_dec == 16'd0) begin
                        n_sets_left = sets_dec;
                        n_phase     = finish_phase;
                    end
                end
                PH_PPS_COUNT: begin
                    n_sets_left = i_in_byte;
                    n_kind      = KIND_PPS;
                    n_phase     = (i_in_byte != 8'd0) ? PH_LEN_HI : PH_DONE;
                end
                default: begin
                    // trailing bytes: ignored
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/a2ab_queue.sv @@
// Small command FIFO between the parser and the output sequencer.
// Depends on a2ab_pkg.
module a2ab_queue
    import a2ab_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR  = AW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == DEPTH_CNT);
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("pop from empty queue");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("queue count did not advance on push");

endmodule

@@ hw/rtl/a2ab_back.sv @@
// Output sequencer: expands queued commands into result items behind an output register.
// Depends on a2ab_pkg.
module a2ab_back
    import a2ab_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_cmd       i_head,
    output logic       o_pop,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    output logic [7:0] o_out_byte,
    output logic       o_unit_kind,
    output logic       o_unit_end,
    output logic       o_run_last
);

    logic [1:0] r_beat, n_beat;
    logic       r_out_valid, n_out_valid;
    logic [7:0] r_byte, n_byte;
    logic       r_kind, n_kind;
    logic       r_end, n_end;
    logic       r_last, n_last;
    logic       load;
    logic       sc_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_beat      <= n_beat;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_kind <= n_kind;
        r_end  <= n_end;
        r_last <= n_last;
    end

    always_comb begin
        load    = !i_empty && (!r_out_valid || i_out_ready);
        sc_last = (r_beat == SC_LAST_BEAT);

        n_beat      = r_beat;
        n_out_valid = r_out_valid && !i_out_ready;
        n_byte      = r_byte;
        n_kind      = r_kind;
        n_end       = r_end;
        n_last      = r_last;
        o_pop       = 1'b0;

        if (load) begin
            n_out_valid = 1'b1;
            n_kind      = i_head.kind;
            if (i_head.is_sc) begin
                n_byte = sc_last ? SC_ONE : SC_ZERO;
                n_end  = sc_last && i_head.unit_end;
                n_last = sc_last;
                n_beat = r_beat + 2'd1;
                o_pop  = sc_last;
            end else begin
                n_byte = i_head.data;
                n_end  = i_head.unit_end;
                n_last = 1'b1;
                o_pop  = 1'b1;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_byte;
    assign o_unit_kind = r_kind;
    assign o_unit_end  = r_end;
    assign o_run_last  = r_last;

    a_beat_on_sc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_beat != 2'd0) |-> (!i_empty && i_head.is_sc))
        else $error("start code interrupted mid-sequence");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_unit_end) |-> o_run_last)
        else $error("unit end on a non-final item");

    a_last_pops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && !(i_head.is_sc && r_beat != SC_LAST_BEAT)) |-> o_pop)
        else $error("command completed without pop");

endmodule

@@ hw/rtl/avcc_to_annexb_converter.sv @@
// Top level of the avcC record to Annex B parameter-set converter.
// Depends on a2ab_pkg, a2ab_front, a2ab_queue, a2ab_back.
//
//  channel | ports                                        | direction
//  --------+----------------------------------------------+----------
//  input   | i_in_valid / o_in_ready, i_in_byte,          | in
//          | i_record_start                               |
//  output  | o_out_valid / i_out_ready, o_out_byte,       | out
//          | o_unit_kind, o_unit_end, o_run_last          |
//
// Cycles: the parser takes one byte per cycle while the command queue has room.
// Payload bytes come out one per cycle while the receiver is ready; each
// length-low byte expands into a four-byte start code (00 00 00 01) in the
// output sequencer, and the queue absorbs the difference in rate. A pushed command
// goes into the queue, then into the output register once that is free.
// Reset: synchronous active-low; clears parser state, queue pointers and the
// output valid. Input and output stall independently through the queue.
module avcc_to_annexb_converter
    import a2ab_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_record_start,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_unit_kind,
    output logic       o_unit_end,
    output logic       o_run_last
);

    logic accept;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;
    t_cmd push_cmd;
    t_cmd head_cmd;

    // Any byte is taken while the queue has room; bytes that push nothing
    // (header, length high, counts, trailing) do not need it, but this keeps
    // ready free of the parse state.
    assign o_in_ready = !q_full;
    assign accept     = i_in_valid && o_in_ready;

    a2ab_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_in_byte      (i_in_byte),
        .i_record_start (i_record_start),
        .o_push         (push),
        .o_cmd          (push_cmd)
    );

    a2ab_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_cmd)
    );

    a2ab_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_head      (head_cmd),
        .o_pop       (pop),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_byte  (o_out_byte),
        .o_unit_kind (o_unit_kind),
        .o_unit_end  (o_unit_end),
        .o_run_last  (o_run_last)
    );

endmodule

@@ bench/avcc_to_annexb_converter_tb.sv @@
// Self-checking bench for avcc_to_annexb_converter: avcC record bytes in, Annex B bytes out.
// Needs a2ab_pkg and the converter RTL. A byte-level parser model predicts every output item.
`timescale 1ns / 100ps

module avcc_to_annexb_converter_tb
    import a2ab_pkg::*;
();

    // One input item with the idle cycles to spend before offering it
    typedef struct {
        logic [7:0]  data;
        logic        start;
        int unsigned gap;
    } t_record_byte;

    // One predicted output item
    typedef struct {
        logic [7:0] data;
        logic       kind;
        logic       unit_end;
        logic       run_last;
    } t_annexb_byte;

    logic       i_clk;
    logic       i_rst_n        = 1'b0;
    logic       i_in_valid     = 1'b0;
    logic [7:0] i_in_byte      = 8'h00;
    logic       i_record_start = 1'b0;
    logic       i_out_ready    = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic       o_unit_kind;
    logic       o_unit_end;
    logic       o_run_last;

    t_record_byte record_bytes[$];   // items waiting for the driver
    t_annexb_byte annexb_expect[$];  // predicted output, oldest first

    // Parser state of the predictor
    t_phase      pr_phase     = PH_HEADER;
    logic [2:0]  pr_hdr_idx   = '0;
    logic [7:0]  pr_sets_left = '0;
    logic [7:0]  pr_len_hi    = '0;
    logic [15:0] pr_pay_left  = '0;
    logic        pr_kind      = KIND_SPS;

    // Handshake bookkeeping
    logic         in_taken  = 1'b0;  // input item accepted at the last rising edge
    logic         out_taken = 1'b0;  // output item accepted at the last rising edge
    t_record_byte tx_cur;
    logic         tx_have   = 1'b0;
    int unsigned  rx_stall  = 0;
    logic         rx_burst  = 1'b0;
    logic         tx_burst  = 1'b0;
    logic         long_seen = 1'b0;
    int unsigned  in_count  = 0;
    int unsigned  out_count = 0;
    int unsigned  byte_total;
    int unsigned  err_count = 0;

    avcc_to_annexb_converter u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_byte      (i_in_byte),
        .i_record_start (i_record_start),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_byte     (o_out_byte),
        .o_unit_kind    (o_unit_kind),
        .o_unit_end     (o_unit_end),
        .o_run_last     (o_run_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        err_count++;
        $display("ERROR at %0t: %s", $time, what);
    endtask

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void expect_byte(input logic [7:0] d, input logic e, input logic l);
        t_annexb_byte ab;
        ab.data     = d;
        ab.kind     = pr_kind;
        ab.unit_end = e;
        ab.run_last = l;
        annexb_expect.push_back(ab);
    endfunction

    // A unit is complete: next length, the PPS count, or the end of the record
    function automatic void close_unit();
        pr_sets_left = pr_sets_left - 8'd1;
        if (pr_sets_left != 8'd0) begin
            pr_phase = PH_LEN_HI;
        end else if (pr_kind == KIND_SPS) begin
            pr_phase = PH_PPS_COUNT;
        end else begin
            pr_phase = PH_DONE;
        end
    endfunction

    function automatic void annexb_predict(input logic [7:0] b, input logic st);
        logic empty;
        logic last_byte;
        // a record start always restarts at header byte 0, even mid-unit
        if (st) begin
            pr_phase   = PH_HEADER;
            pr_hdr_idx = '0;
        end
        case (pr_phase)
            PH_HEADER: begin
                if (pr_hdr_idx == HEADER_LAST) begin
                    pr_sets_left = b & SPS_COUNT_MASK;
                    pr_kind      = KIND_SPS;
                    pr_hdr_idx   = '0;
                    pr_phase     = (pr_sets_left != 8'd0) ? PH_LEN_HI : PH_PPS_COUNT;
                end else begin
                    pr_hdr_idx = pr_hdr_idx + 3'd1;
                end
            end
            PH_LEN_HI: begin
                pr_len_hi = b;
                pr_phase  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                // start code; a zero-length unit ends on its 0x01
                pr_pay_left = {pr_len_hi, b};
                empty       = (pr_pay_left == 16'd0);
                expect_byte(SC_ZERO, 1'b0, 1'b0);
                expect_byte(SC_ZERO, 1'b0, 1'b0);
                expect_byte(SC_ZERO, 1'b0, 1'b0);
                expect_byte(SC_ONE, empty, 1'b1);
                if (empty) begin
                    close_unit();
                end else begin
                    pr_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                pr_pay_left = pr_pay_left - 16'd1;
                last_byte   = (pr_pay_left == 16'd0);
                expect_byte(b, last_byte, 1'b1);
                if (last_byte) begin
                    close_unit();
                end
            end
            PH_PPS_COUNT: begin
                pr_sets_left = b;
                pr_kind      = KIND_PPS;
                pr_phase     = (b != 8'd0) ? PH_LEN_HI : PH_DONE;
            end
            default: ;  // trailing bytes are dropped
        endcase
    endfunction

    task automatic check_annexb_byte();
        t_annexb_byte want;
        if (annexb_expect.size() == 0) begin
            report_mismatch($sformatf("output item %0d (byte %02h) not predicted",
                                      out_count, o_out_byte));
            return;
        end
        want = annexb_expect.pop_front();
        if (o_out_byte !== want.data)
            report_mismatch($sformatf("item %0d out_byte %02h, want %02h",
                                      out_count, o_out_byte, want.data));
        if (o_unit_kind !== want.kind)
            report_mismatch($sformatf("item %0d unit_kind %b, want %b",
                                      out_count, o_unit_kind, want.kind));
        if (o_unit_end !== want.unit_end)
            report_mismatch($sformatf("item %0d unit_end %b, want %b",
                                      out_count, o_unit_end, want.unit_end));
        if (o_run_last !== want.run_last)
            report_mismatch($sformatf("item %0d run_last %b, want %b",
                                      out_count, o_run_last, want.run_last));
    endtask

    // ------------------------------------------------------------------
    // Monitor: sample both handshakes at the rising edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        in_taken  <= i_rst_n && i_in_valid && (o_in_ready === 1'b1);
        out_taken <= i_rst_n && (o_out_valid === 1'b1) && i_out_ready;
        if (i_rst_n) begin
            // the prediction is queued before any output of this edge is checked
            if (i_in_valid && o_in_ready === 1'b1) begin
                annexb_predict(i_in_byte, i_record_start);
                in_count++;
            end
            if (o_out_valid === 1'b1 && i_out_ready) begin
                check_annexb_byte();
                out_count++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: offers the queued record bytes at the falling edge
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            // nothing on offer, or the last item just went in
            if (!tx_have && record_bytes.size() != 0) begin
                tx_cur  = record_bytes.pop_front();
                tx_have = 1'b1;
            end
            if (tx_have && tx_cur.gap == 0) begin
                i_in_valid     <= 1'b1;
                i_in_byte      <= tx_cur.data;
                i_record_start <= tx_cur.start;
                tx_have = 1'b0;
            end else begin
                if (tx_have) tx_cur.gap--;
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure, one stall length drawn per output item
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (out_taken || !i_out_ready) begin
            if (out_taken) begin
                if ($urandom_range(0, 47) == 0) rx_burst = !rx_burst;
                rx_stall = rx_burst ? 0 : $urandom_range(0, 16);
            end
            if (rx_stall != 0) begin
                rx_stall--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    task automatic queue_byte(input logic [7:0] b, input logic st);
        t_record_byte rb;
        // sender alternates between gappy stretches and back-to-back bursts
        if ($urandom_range(0, 63) == 0) tx_burst = !tx_burst;
        rb.data  = b;
        rb.start = st;
        rb.gap   = tx_burst ? 0 : $urandom_range(0, 16);
        record_bytes.push_back(rb);
    endtask

    task automatic queue_unit(input int unsigned len);
        queue_byte(len[15:8], 1'b0);
        queue_byte(len[7:0], 1'b0);
        repeat (len) queue_byte(8'($urandom), 1'b0);
    endtask

    // Mostly short units; empty ones and occasional long units (nonzero length high byte)
    function automatic int unsigned draw_len();
        if (!long_seen && $urandom_range(0, 9) == 0) begin
            long_seen = 1'b1;
            return 256 + $urandom_range(0, 4);
        end
        if ($urandom_range(0, 199) == 0) return 256 + $urandom_range(0, 4);
        if ($urandom_range(0, 7) == 0) return 0;
        return $urandom_range(1, 8);
    endfunction

    task automatic queue_record();
        int unsigned n_sps;
        int unsigned n_units;
        n_sps = ($urandom_range(0, 19) == 0) ? 31 : $urandom_range(0, 3);
        queue_byte(8'($urandom), 1'b1);
        repeat (4) queue_byte(8'($urandom), 1'b0);
        // count byte: reserved upper bits random
        queue_byte(8'(($urandom & 32'hE0) | n_sps), 1'b0);
        repeat (n_sps) queue_unit(draw_len());
        if ($urandom_range(0, 14) == 0) begin
            // big PPS count, cut short by the next record start
            queue_byte(8'($urandom_range(128, 255)), 1'b0);
            n_units = $urandom_range(0, 3);
        end else begin
            n_units = $urandom_range(0, 3);
            queue_byte(8'(n_units), 1'b0);
        end
        repeat (n_units) queue_unit(draw_len());
        repeat ($urandom_range(0, 3)) queue_byte(8'($urandom), 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Sequence: fill the stimulus, release reset, wait for the drain
    // ------------------------------------------------------------------
    initial begin
        int unsigned goal;
        int unsigned mark;
        int unsigned sel;

        // Record without a leading record start: parsed from header byte 0.
        // One SPS of two bytes, then one empty PPS (its 0x01 carries the end).
        queue_byte(8'h01, 1'b0);
        repeat (4) queue_byte(8'h00, 1'b0);
        queue_byte(8'hE1, 1'b0);
        queue_unit(2);
        record_bytes[record_bytes.size() - 2].data = 8'hFF;
        record_bytes[record_bytes.size() - 1].data = 8'h00;
        queue_byte(8'h01, 1'b0);
        queue_unit(0);

        // Zero SPS count straight to a zero PPS count; the trailing byte is dropped
        queue_byte(8'hFF, 1'b1);
        repeat (4) queue_byte(8'hFF, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);

        // Record abandoned inside an SPS payload by the next record start
        queue_byte(8'h01, 1'b1);
        repeat (4) queue_byte(8'h55, 1'b0);
        queue_byte(8'h01, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h03, 1'b0);
        queue_byte(8'h80, 1'b0);

        // Random part: whole records, truncated records and loose noise
        goal = record_bytes.size() + 310;
        while (record_bytes.size() < goal) begin
            sel = $urandom_range(0, 19);
            if (sel < 15) begin
                queue_record();
            end else if (sel < 18) begin
                mark = record_bytes.size();
                queue_record();
                repeat ($urandom_range(1, record_bytes.size() - mark - 1))
                    void'(record_bytes.pop_back());
            end else begin
                repeat ($urandom_range(1, 8))
                    queue_byte(8'($urandom), $urandom_range(0, 7) == 0);
            end
        end
        byte_total = record_bytes.size();

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (in_count != byte_total || annexb_expect.size() != 0) @(posedge i_clk);
        // keep watching to catch anything emitted beyond the prediction
        repeat (16) @(posedge i_clk);
        if (annexb_expect.size() != 0)
            report_mismatch($sformatf("%0d predicted items never came out",
                                      annexb_expect.size()));
        if (err_count == 0) begin
            $display("avcc_to_annexb_converter verification clean");
        end else begin
            $display("avcc_to_annexb_converter verification failed");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("avcc_to_annexb_converter verification failed");
        $finish;
    end

endmodule
